@@ src/swm_pkg.sv @@
package swm_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int WINDOW_LEN_W   = 7;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [APB_ADDR_W-1:0]   ADDR_WINDOW_LEN  = 3'd0;
  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RESET = 7'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // operation applied to the whole cell row in the same cycle
  typedef struct packed {
    logic clear;
    logic shift;
    logic append;
  } swm_ctrl_t;

endpackage

@@ src/swm_in_if.sv @@
interface swm_in_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

@@ src/swm_out_if.sv @@
interface swm_out_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t window_min;

  modport source (output valid, output window_min, input ready);
  modport sink (input valid, input window_min, output ready);
endinterface

@@ src/swm_cell.sv @@
module swm_cell import swm_pkg::*; #(
  parameter int PW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  swm_ctrl_t     ctrl,
  input  sample_t       sample,
  input  logic [PW-1:0] position,
  input  logic          prev_kept,
  input  logic          up_valid,
  input  sample_t       up_value,
  input  logic [PW-1:0] up_pos,
  output logic          valid,
  output sample_t       value,
  output logic [PW-1:0] pos,
  output logic          kept
);

  // entries not below the new sample leave the back of the queue
  assign kept = valid && (value < sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= up_valid;
    end else if (ctrl.append && !kept) begin
      valid <= prev_kept;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= up_value;
      pos   <= up_pos;
    end else if (ctrl.append && !kept && prev_kept) begin
      value <= sample;
      pos   <= position;
    end
  end

endmodule

@@ src/sliding_window_minimum_top.sv @@
// channel  | direction | payload              | handshake
// in_ch    | sink      | sample[31:0] restart | valid / ready
// out_ch   | source    | window_min[31:0]     | valid / ready
// apb      | slave     | window_len @ 0x0     | psel / penable, pready tied high
//
// an item is accepted, then the d front entries that leave the window (0 or 1 at a fixed
// window_len) are shifted out, then it is appended; the cell row moves one entry per cycle
// rst clears the queue, the position counter and sets window_len to 1
// a result waits in the output register; the next transaction is accepted meanwhile,
// its front drops go on, and its append holds until the output register is free
module sliding_window_minimum_top import swm_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  swm_in_if.sink                in_ch,
  swm_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int POS_MOD = 2 * MAX_WINDOW;
  localparam int PW      = $clog2(POS_MOD);
  localparam int DW      = (PW + 1 > WINDOW_LEN_W) ? PW + 1 : WINDOW_LEN_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                    state;
  logic [WINDOW_LEN_W-1:0] window_len;
  logic [PW-1:0]           position;
  logic [PW-1:0]           pos_inc;
  sample_t                 cur_sample;
  logic                    out_valid;
  sample_t                 window_min;

  logic                    accept;
  logic                    slot_free;
  logic                    drop_front;
  swm_ctrl_t               ctrl;

  logic [DW-1:0] pos_ext, front_ext, front_age, w_ext, k_eff;

  logic          cell_valid [MAX_WINDOW];
  sample_t       cell_value [MAX_WINDOW];
  logic [PW-1:0] cell_pos   [MAX_WINDOW];
  logic          cell_kept  [MAX_WINDOW];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WINDOW_LEN) ? APB_DATA_W'(window_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_WINDOW_LEN)) begin
      window_len <= pwdata[WINDOW_LEN_W-1:0];
    end
  end

  // window check on the front cell
  always_comb begin
    pos_ext   = DW'(position);
    front_ext = DW'(cell_pos[0]);
    if (pos_ext >= front_ext) begin
      front_age = pos_ext - front_ext;
    end else begin
      front_age = pos_ext + DW'(POS_MOD) - front_ext;
    end
    w_ext = DW'(window_len);
    if (w_ext == '0) begin
      k_eff = DW'(1);
    end else if (w_ext > DW'(MAX_WINDOW)) begin
      k_eff = DW'(MAX_WINDOW);
    end else begin
      k_eff = w_ext;
    end
  end

  assign drop_front = cell_valid[0] && (front_age >= k_eff);
  assign pos_inc    = (position == PW'(POS_MOD - 1)) ? '0 : PW'(position + PW'(1));

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid || out_ch.ready;

  assign ctrl.clear  = accept && in_ch.restart;
  assign ctrl.shift  = (state == S_RUN) && drop_front;
  assign ctrl.append = (state == S_RUN) && !drop_front && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= S_RUN;
        if (in_ch.restart) begin
          position <= '0;
        end
      end else if (ctrl.append) begin
        state    <= S_IDLE;
        position <= pos_inc;
      end
      if (ctrl.append) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sample <= in_ch.sample;
    end
    if (ctrl.append) begin
      window_min <= cell_kept[0] ? cell_value[0] : cur_sample;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.window_min = window_min;

  // cell 0 is the queue front, entries move toward it on a drop
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic          prev_kept;
    logic          up_valid;
    sample_t       up_value;
    logic [PW-1:0] up_pos;

    if (i == 0) begin : g_first
      assign prev_kept = 1'b1;
    end else begin : g_inner
      assign prev_kept = cell_kept[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign up_valid = 1'b0;
      assign up_value = '0;
      assign up_pos   = '0;
    end else begin : g_mid
      assign up_valid = cell_valid[i+1];
      assign up_value = cell_value[i+1];
      assign up_pos   = cell_pos[i+1];
    end

    swm_cell #(
      .PW(PW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sample   (cur_sample),
      .position (position),
      .prev_kept(prev_kept),
      .up_valid (up_valid),
      .up_value (up_value),
      .up_pos   (up_pos),
      .valid    (cell_valid[i]),
      .value    (cell_value[i]),
      .pos      (cell_pos[i]),
      .kept     (cell_kept[i])
    );
  end

endmodule

@@ src/swm_checker.sv @@
module swm_checker import swm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sample_t               window_min,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_min))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted before the first finished");

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  // a written window length reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr == ADDR_WINDOW_LEN)
      ##1 (psel && !pwrite && paddr == ADDR_WINDOW_LEN)
    |-> prdata[WINDOW_LEN_W-1:0] == $past(pwdata[WINDOW_LEN_W-1:0]))
    else $error("window_len readback mismatch");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind sliding_window_minimum_top swm_checker u_swm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .window_min(out_ch.window_min),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

@@ tb/sv/tb_sliding_window_minimum_top.sv @@
`timescale 1ns / 1ps

module tb_sliding_window_minimum_top import swm_pkg::*; ();

  localparam int POS_W         = $clog2(2 * MAX_WINDOW_DEF);
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 170;
  // a shrinking write can make one sample drop a whole window of front entries
  localparam int SETTLE_CYCLES = 80;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum {SHAPE_RISE, SHAPE_FALL, SHAPE_FEW, SHAPE_WIDE, SHAPE_EDGE} shape_t;
  typedef enum {RX_FREE, RX_COIN, RX_PATTERN} rx_style_t;

  typedef struct {
    row_kind_t               kind;
    logic [APB_ADDR_W-1:0]   addr;
    logic [APB_DATA_W-1:0]   data;
    logic                    restart;
    logic                    typed;
    sample_t                 want;
  } dir_row_t;

  typedef struct packed {
    sample_t          value;
    logic [POS_W-1:0] pos;
  } run_entry_t;

  typedef struct packed {
    logic    typed;
    sample_t want;
  } row_check_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  sliding_window_minimum_top #(.MAX_WINDOW(MAX_WINDOW_DEF)) u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // predictor state
  run_entry_t              kept_run[$];
  logic [POS_W-1:0]        pos_counter = '0;
  logic [WINDOW_LEN_W-1:0] window_cfg  = WINDOW_LEN_RESET;

  sample_t    pending_mins[$];
  row_check_t row_checks[$];
  int         mismatches = 0;

  shape_t    shape          = SHAPE_WIDE;
  int        shape_left     = 0;
  sample_t   last_sample    = '0;
  int        burst_left     = 0;
  bit        tx_gappy       = 1'b1;
  bit        tx_on          = 1'b0;
  rx_style_t rx_style       = RX_COIN;
  int        rx_hold_cycles = 0;

  dir_row_t script [27] = '{
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    // zero window behaves as one
    '{ROW_WRITE,  ADDR_WINDOW_LEN, 32'd0,         1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'hA5A5_A5A5, 1'b0, 1'b1, 32'hA5A5_A5A5},
    '{ROW_WRITE,  ADDR_WINDOW_LEN, 32'd4,         1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd10,        1'b1, 1'b1, 32'd10},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd20,        1'b0, 1'b1, 32'd10},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd5,         1'b0, 1'b1, 32'd5},
    // equal sample replaces the older one
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd5,         1'b0, 1'b1, 32'd5},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd7,         1'b0, 1'b1, 32'd5},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd9,         1'b0, 1'b1, 32'd5},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd8,         1'b0, 1'b1, 32'd5},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd8,         1'b0, 1'b1, 32'd7},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd8},
    // shrink to 2: one front entry leaves, the back one is displaced by the equal sample
    '{ROW_WRITE,  ADDR_WINDOW_LEN, 32'd2,         1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd1,         1'b0, 1'b1, 32'd1},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd2,         1'b0, 1'b1, 32'd1},
    // above max, upper data bits set
    '{ROW_WRITE,  ADDR_WINDOW_LEN, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd3,         1'b1, 1'b1, 32'd3},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'hFFFF_FFFE, 1'b0, 1'b0, 32'd0},
    '{ROW_WRITE,  ADDR_UNMAPPED,   32'd5,         1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd4,         1'b0, 1'b0, 32'd0},
    '{ROW_WRITE,  ADDR_WINDOW_LEN, 32'd1,         1'b0, 1'b0, 32'd0},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd9,         1'b0, 1'b1, 32'd9},
    '{ROW_SAMPLE, ADDR_WINDOW_LEN, 32'd6,         1'b1, 1'b1, 32'd6}
  };

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic sample_t predict_window_min(input sample_t x, input logic clr);
    logic [POS_W-1:0] age;
    int               span;
    if (clr) begin
      kept_run.delete();
      pos_counter = '0;
    end
    span = (window_cfg == 0) ? 1 :
           (int'(window_cfg) > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(window_cfg);
    // distances wrap at twice the window depth
    while (kept_run.size() > 0) begin
      age = pos_counter - kept_run[0].pos;
      if (int'(age) < span) break;
      kept_run.delete(0);
    end
    while (kept_run.size() > 0 && kept_run[$].value >= x)
      kept_run.delete(kept_run.size() - 1);
    kept_run.insert(kept_run.size(), run_entry_t'{x, pos_counter});
    pos_counter++;
    return kept_run[0].value;
  endfunction

  function automatic sample_t draw_sample();
    sample_t v;
    if (shape_left == 0) begin
      shape      = shape_t'($urandom_range(0, 4));
      shape_left = $urandom_range(8, 100);
    end
    shape_left--;
    case (shape)
      SHAPE_RISE: begin
        v = (last_sample > 32'hFFFF_FFF0) ? sample_t'($urandom_range(0, 255))
                                          : last_sample + $urandom_range(1, 3);
      end
      SHAPE_FALL: begin
        v = (last_sample < 32'd16) ? sample_t'($urandom())
                                   : last_sample - $urandom_range(1, 3);
      end
      SHAPE_FEW:  v = $urandom_range(0, 7);
      SHAPE_WIDE: v = $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'hFFFF_FFFE;
          4:       v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
    endcase
    last_sample = v;
    return v;
  endfunction

  task automatic push_sample(input sample_t v, input logic clr, input logic typed,
                             input sample_t want);
    row_checks.insert(row_checks.size(), row_check_t'{typed, want});
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= v;
    in_ch.restart <= clr;
    tx_on = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic sender_idle(input int cycles);
    if (tx_on) in_ch.valid <= 1'b0;
    tx_on = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || !tx_gappy) ? 0 : $urandom_range(1, 6);
      if (gap > 0) sender_idle(gap);
    end
  endtask

  task automatic drain_results();
    sender_idle(0);
    while (row_checks.size() != 0 || pending_mins.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (a == ADDR_WINDOW_LEN) window_cfg = d[WINDOW_LEN_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WINDOW_LEN;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_W'(window_cfg))
      flag_mismatch($sformatf("window_len read %h, want %h", prdata, window_cfg));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(a, d);
    apb_read_check();
  endtask

  always @(posedge clk) begin : accept_mon
    row_check_t chk;
    sample_t    guess;
    if (!rst && in_ch.valid && in_ch.ready) begin
      guess = predict_window_min(in_ch.sample, in_ch.restart);
      chk   = row_checks[0];
      row_checks.delete(0);
      pending_mins.insert(pending_mins.size(), chk.typed ? chk.want : guess);
    end
  end

  always @(posedge clk) begin : result_mon
    sample_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_mins.size() == 0) begin
        flag_mismatch($sformatf("window_min %h with no transaction pending",
                                out_ch.window_min));
      end else begin
        want = pending_mins[0];
        pending_mins.delete(0);
        if (out_ch.window_min !== want)
          flag_mismatch($sformatf("window_min %h, want %h", out_ch.window_min, want));
      end
    end
  end

  initial begin : rx_drive
    int tick;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        case (rx_style)
          RX_FREE:    out_ch.ready <= 1'b1;
          RX_COIN:    out_ch.ready <= ($urandom_range(0, 99) < 65);
          default:    out_ch.ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [WINDOW_LEN_W-1:0] w;
    logic [APB_DATA_W-1:0]   cfg_word;
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        set_window(script[i].addr, script[i].data);
      end else begin
        push_sample(script[i].data, script[i].restart, script[i].typed, script[i].want);
        pace_sender();
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       w = 7'd64;
        1:       w = 7'd1;
        2:       w = 7'd127;
        3:       w = 7'd0;
        4:       w = 7'd2;
        5:       w = 7'd65;
        6:       w = 7'($urandom_range(3, 63));
        7:       w = 7'd64;
        default: w = 7'($urandom_range(0, 127));
      endcase
      cfg_word = $urandom();
      cfg_word[WINDOW_LEN_W-1:0] = w;
      set_window(ADDR_WINDOW_LEN, cfg_word);
      rx_style = rx_style_t'(ph % 3);
      tx_gappy = (ph != 0);
      // long receiver stall with the sender pushing back to back
      if (ph == 0) rx_hold_cycles = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        push_sample(draw_sample(), ($urandom_range(0, 99) < 3), 1'b0, '0);
        pace_sender();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
src/swm_pkg.sv
src/swm_in_if.sv
src/swm_out_if.sv
src/swm_cell.sv
src/sliding_window_minimum_top.sv
src/swm_checker.sv
tb/sv/tb_sliding_window_minimum_top.sv
